// File: hw/rtl/jsu_pkg.sv
// Package for the string unescape block: mode codes, result record type,
// status codes, character constants and the hex digit decoder.
// No dependencies.
`default_nettype none

package jsu_pkg;

   // Decoder mode, one-hot.
   typedef enum logic [6:0] {
      MODE_IDLE = 7'b000_0001,
      MODE_BODY = 7'b000_0010,
      MODE_ESC  = 7'b000_0100,
      MODE_HEX1 = 7'b000_1000,
      MODE_HEX2 = 7'b001_0000,
      MODE_HEX3 = 7'b010_0000,
      MODE_HEX4 = 7'b100_0000
   } mode_type;

   // Result status codes.
   localparam logic [1:0] STATUS_DATA  = 2'd0;
   localparam logic [1:0] STATUS_END   = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   // Characters with a special meaning.
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_QMARK     = 8'h3F;
   localparam logic [7:0] CHAR_DEL       = 8'h7F;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;

   // One decoded result transaction.
   typedef struct packed {
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] byte_c;
      logic [1:0] byte_count;
      logic [1:0] status;
   } result_type;

   // Hex digit decode: bit 4 set means the character is a valid digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      logic [4:0] res;
      res = 5'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         res = {1'b1, ch[3:0]};
      end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
         res = {1'b1, ch[3:0] + 4'd9};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/json_string_unescape_utf8_top.sv
// String unescape block with UTF-8 output: one byte in per cycle unless stalled,
// at most one result of up to three bytes per byte. Depends on jsu_pkg.
// A result is registered in the output register, or in the skid register while
// the output still holds one. Throughput: one byte per cycle unless stalled; the
// decode is a short combinational path from the mode and hex registers into the
// result register, with a one-entry skid register so that bytes keep flowing while
// a result waits. The input stalls only while both output and skid hold a result.
// Reset: synchronous, active high; clears the mode to idle, the hex state and
// both result slots.
`default_nettype none

module json_string_unescape_utf8_top (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [7:0] req_in_byte,
   input  wire        req_begin_req,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [7:0] rsp_byte_a,
   output logic [7:0] rsp_byte_b,
   output logic [7:0] rsp_byte_c,
   output logic [1:0] rsp_byte_count,
   output logic [1:0] rsp_status
);
   import jsu_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [15:0] hex_accum_ff, hex_accum_in;
   logic        hex_bad_ff, hex_bad_in;

   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;
   logic        skid_valid_ff, skid_valid_in;
   result_type  skid_ff, skid_in;

   logic        req_take;
   logic        rsp_take;
   logic        has_result;
   result_type  result;
   logic [4:0]  digit;
   logic [15:0] code;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign digit     = hex_digit(req_in_byte);

   // Decode one byte against the current mode.
   always_comb begin
      mode_in      = mode_ff;
      hex_accum_in = hex_accum_ff;
      hex_bad_in   = hex_bad_ff;
      has_result   = 1'b0;
      result       = '0;
      code         = 16'd0;
      if (req_begin_req) begin
         mode_in      = MODE_BODY;
         hex_accum_in = 16'd0;
         hex_bad_in   = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_BODY: begin
               if (req_in_byte == CHAR_QUOTE) begin
                  mode_in       = MODE_IDLE;
                  has_result    = 1'b1;
                  result.status = STATUS_END;
               end else if (req_in_byte == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end else if (req_in_byte < CHAR_SPACE || req_in_byte == CHAR_DEL) begin
                  mode_in       = MODE_IDLE;
                  has_result    = 1'b1;
                  result.status = STATUS_ERROR;
               end else begin
                  has_result        = 1'b1;
                  result.byte_a     = req_in_byte;
                  result.byte_count = 2'd1;
               end
            end
            MODE_ESC: begin
               has_result        = 1'b1;
               result.byte_count = 2'd1;
               mode_in           = MODE_BODY;
               case (req_in_byte)
                  CHAR_QUOTE:     result.byte_a = CHAR_QUOTE;
                  CHAR_BACKSLASH: result.byte_a = CHAR_BACKSLASH;
                  CHAR_SLASH:     result.byte_a = CHAR_SLASH;
                  CHAR_LOWER_B:   result.byte_a = 8'h08;
                  CHAR_LOWER_F:   result.byte_a = 8'h0C;
                  CHAR_LOWER_N:   result.byte_a = 8'h0A;
                  CHAR_LOWER_R:   result.byte_a = 8'h0D;
                  CHAR_LOWER_T:   result.byte_a = 8'h09;
                  CHAR_LOWER_U: begin
                     has_result        = 1'b0;
                     result.byte_count = 2'd0;
                     mode_in           = MODE_HEX1;
                     hex_accum_in      = 16'd0;
                     hex_bad_in        = 1'b0;
                  end
                  default: begin
                     result.byte_count = 2'd0;
                     result.status     = STATUS_ERROR;
                     mode_in           = MODE_IDLE;
                  end
               endcase
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
               if (req_in_byte == CHAR_NUL) begin
                  mode_in       = MODE_IDLE;
                  has_result    = 1'b1;
                  result.status = STATUS_ERROR;
               end else begin
                  if (digit[4]) begin
                     hex_accum_in = {hex_accum_ff[11:0], digit[3:0]};
                  end else begin
                     hex_bad_in = 1'b1;
                  end
                  if (mode_ff == MODE_HEX1) begin
                     mode_in = MODE_HEX2;
                  end else if (mode_ff == MODE_HEX2) begin
                     mode_in = MODE_HEX3;
                  end else if (mode_ff == MODE_HEX3) begin
                     mode_in = MODE_HEX4;
                  end else begin
                     // Last digit: encode the code point as UTF-8.
                     mode_in    = MODE_BODY;
                     has_result = 1'b1;
                     code       = hex_bad_in ? {8'd0, CHAR_QMARK} : hex_accum_in;
                     if (code[15:7] == 9'd0) begin
                        result.byte_a     = code[7:0];
                        result.byte_count = 2'd1;
                     end else if (code[15:11] == 5'd0) begin
                        result.byte_a     = {3'b110, code[10:6]};
                        result.byte_b     = {2'b10, code[5:0]};
                        result.byte_count = 2'd2;
                     end else begin
                        result.byte_a     = {4'b1110, code[15:12]};
                        result.byte_b     = {2'b10, code[11:6]};
                        result.byte_c     = {2'b10, code[5:0]};
                        result.byte_count = 2'd3;
                     end
                  end
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   // Route a new result into the output register or, while it waits, the skid.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_take) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (req_take && has_result) begin
         if (out_valid_ff && !rsp_take) begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end else begin
            out_valid_in = 1'b1;
            out_in       = result;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         hex_accum_ff  <= 16'd0;
         hex_bad_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            mode_ff      <= mode_in;
            hex_accum_ff <= hex_accum_in;
            hex_bad_ff   <= hex_bad_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_byte_a     = out_ff.byte_a;
   assign rsp_byte_b     = out_ff.byte_b;
   assign rsp_byte_c     = out_ff.byte_c;
   assign rsp_byte_count = out_ff.byte_count;
   assign rsp_status     = out_ff.status;

`ifndef SYNTHESIS
   // The skid slot is only filled behind a waiting output transaction.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output is empty");

   // End and error results carry no bytes; data results carry at least one.
   a_count_vs_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == STATUS_DATA) == (rsp_byte_count != 2'd0)))
      else $error("byte count does not match result status");

   // A result with begin asserted never appears; a begin byte yields nothing.
   a_begin_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_begin_req && !out_valid_ff) |=> !rsp_valid)
      else $error("opening quote produced a result");

   // A closing quote or error returns the decoder to idle.
   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      (req_take && has_result && result.status != STATUS_DATA)
         |=> mode_ff == MODE_IDLE)
      else $error("decoder not idle after end or error");
`endif

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the JSON string unescape block with UTF-8 output.
// Holds its own decoder model and drives directed and random strings through the
// valid/stall ports of json_string_unescape_utf8_top; needs jsu_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_top;
   import jsu_pkg::*;

   // One source byte as offered on the request channel.
   typedef struct packed {
      logic [7:0] ch;
      logic       start;
   } src_byte_type;

   localparam int TARGET_BYTES   = 1500;
   localparam int IDLE_PERCENT   = 15;
   localparam int STALL_START    = 400;
   localparam int STALL_CYCLES   = 300;
   localparam int QUIET_FIRST    = 1200;
   localparam int QUIET_LAST     = 1700;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 100;

   localparam logic [7:0] DIGIT_ZERO  = 8'h30;
   localparam logic [7:0] UPPER_A     = 8'h41;
   localparam logic [7:0] LOWER_A     = 8'h61;
   localparam logic [7:0] ANY_BYTE_LO = 8'h23;
   localparam logic [7:0] ANY_BYTE_HI = 8'h5B;
   localparam logic [7:0] CTRL_LAST   = 8'h1F;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_begin_req = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_byte_a;
   logic [7:0] rsp_byte_b;
   logic [7:0] rsp_byte_c;
   logic [1:0] rsp_byte_count;
   logic [1:0] rsp_status;

   // Source bytes waiting to be offered, and the decoded results still owed.
   src_byte_type pending_bytes[$];
   result_type   owed_results[$];

   // Decoder model state.
   mode_type    dec_mode = MODE_IDLE;
   logic [15:0] dec_accum = 16'h0000;
   logic        dec_bad = 1'b0;

   int cycle_count = 0;
   int counted_bytes = 0;
   int strings_begun = 0;
   int bytes_taken = 0;
   int results_checked = 0;
   int data_results = 0;
   int end_results = 0;
   int error_results = 0;
   int three_byte_results = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   wire quiet_stretch = (cycle_count >= QUIET_FIRST) && (cycle_count < QUIET_LAST);

   json_string_unescape_utf8_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_begin_req  (req_begin_req),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_a     (rsp_byte_a),
      .rsp_byte_b     (rsp_byte_b),
      .rsp_byte_c     (rsp_byte_c),
      .rsp_byte_count (rsp_byte_count),
      .rsp_status     (rsp_status)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Value of a hex digit character, or -1 when the character is not one.
   function automatic int hex_val(input logic [7:0] ch);
      if (ch >= DIGIT_ZERO && ch < DIGIT_ZERO + 8'd10) begin
         return int'(ch - DIGIT_ZERO);
      end
      if (ch >= LOWER_A && ch < LOWER_A + 8'd6) begin
         return int'(ch - LOWER_A) + 10;
      end
      if (ch >= UPPER_A && ch < UPPER_A + 8'd6) begin
         return int'(ch - UPPER_A) + 10;
      end
      return -1;
   endfunction

   // Byte that a one-character escape stands for, or -1 for anything else.
   function automatic int unescape_simple(input logic [7:0] ch);
      case (ch)
         CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: return int'(ch);
         CHAR_LOWER_B: return 8'h08;
         CHAR_LOWER_F: return 8'h0C;
         CHAR_LOWER_N: return 8'h0A;
         CHAR_LOWER_R: return 8'h0D;
         CHAR_LOWER_T: return 8'h09;
         default: return -1;
      endcase
   endfunction

   task automatic post_result(input logic [1:0] status, input logic [1:0] count,
                              input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c);
      result_type res;
      res.byte_a = a;
      res.byte_b = b;
      res.byte_c = c;
      res.byte_count = count;
      res.status = status;
      owed_results.push_back(res);
   endtask

   task automatic abort_string();
      dec_mode = MODE_IDLE;
      post_result(STATUS_ERROR, 2'd0, 8'h00, 8'h00, 8'h00);
   endtask

   // Decoder model: advances the state on one accepted byte and queues the
   // result that the byte produces, if any.
   task automatic decode_byte(input logic [7:0] ch, input logic start);
      int          val;
      logic [15:0] cp;
      if (start) begin
         dec_mode = MODE_BODY;
         dec_accum = 16'h0000;
         dec_bad = 1'b0;
      end else begin
         case (dec_mode)
            MODE_BODY: begin
               if (ch == CHAR_QUOTE) begin
                  dec_mode = MODE_IDLE;
                  post_result(STATUS_END, 2'd0, 8'h00, 8'h00, 8'h00);
               end else if (ch == CHAR_BACKSLASH) begin
                  dec_mode = MODE_ESC;
               end else if (ch < CHAR_SPACE || ch == CHAR_DEL) begin
                  abort_string();
               end else begin
                  post_result(STATUS_DATA, 2'd1, ch, 8'h00, 8'h00);
               end
            end
            MODE_ESC: begin
               val = unescape_simple(ch);
               if (ch == CHAR_LOWER_U) begin
                  dec_mode = MODE_HEX1;
                  dec_accum = 16'h0000;
                  dec_bad = 1'b0;
               end else if (val < 0) begin
                  abort_string();
               end else begin
                  dec_mode = MODE_BODY;
                  post_result(STATUS_DATA, 2'd1, val[7:0], 8'h00, 8'h00);
               end
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
               if (ch == CHAR_NUL) begin
                  abort_string();
               end else begin
                  val = hex_val(ch);
                  if (val < 0) begin
                     dec_bad = 1'b1;
                  end else begin
                     dec_accum = {dec_accum[11:0], val[3:0]};
                  end
                  case (dec_mode)
                     MODE_HEX1: dec_mode = MODE_HEX2;
                     MODE_HEX2: dec_mode = MODE_HEX3;
                     MODE_HEX3: dec_mode = MODE_HEX4;
                     default: begin
                        // Last digit: emit the code point as UTF-8.
                        dec_mode = MODE_BODY;
                        cp = dec_bad ? {8'h00, CHAR_QMARK} : dec_accum;
                        if (cp < 16'h0080) begin
                           post_result(STATUS_DATA, 2'd1, cp[7:0], 8'h00, 8'h00);
                        end else if (cp < 16'h0800) begin
                           post_result(STATUS_DATA, 2'd2, {3'b110, cp[10:6]},
                                       {2'b10, cp[5:0]}, 8'h00);
                        end else begin
                           post_result(STATUS_DATA, 2'd3, {4'b1110, cp[15:12]},
                                       {2'b10, cp[11:6]}, {2'b10, cp[5:0]});
                        end
                     end
                  endcase
               end
            end
            default: dec_mode = MODE_IDLE;
         endcase
      end
   endtask

   // Stimulus helpers.
   task automatic push_byte(input logic [7:0] ch, input logic start);
      src_byte_type item;
      item.ch = ch;
      item.start = start;
      pending_bytes.push_back(item);
      counted_bytes++;
      if (start) begin
         strings_begun++;
      end
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return DIGIT_ZERO + 8'(nib);
      end
      return ($urandom_range(1) ? LOWER_A : UPPER_A) + 8'(nib) - 8'd10;
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] ch;
      do begin
         ch = 8'($urandom_range(1, 255));
      end while (hex_val(ch) >= 0);
      return ch;
   endfunction

   task automatic push_escape(input logic [7:0] ch);
      push_byte(CHAR_BACKSLASH, 1'b0);
      push_byte(ch, 1'b0);
   endtask

   // A \u group for the given code; one digit may be spoiled on purpose.
   task automatic push_unicode(input logic [15:0] cp, input bit spoil);
      int bad_pos;
      bad_pos = spoil ? $urandom_range(0, 3) : -1;
      push_escape(CHAR_LOWER_U);
      for (int i = 3; i >= 0; i--) begin
         push_byte((i == bad_pos) ? non_hex_byte() : hex_char(cp[i*4 +: 4]), 1'b0);
      end
   endtask

   // One random string: mostly well formed, with some broken pieces.
   task automatic push_random_string();
      int         len;
      int         roll;
      int         digits;
      bit         aborted;
      logic [7:0] ch;
      logic [15:0] cp;
      aborted = 1'b0;
      len = $urandom_range(0, 12);
      push_byte(8'($urandom_range(0, 255)), 1'b1);
      for (int k = 0; k < len && !aborted; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            ch = 8'($urandom_range(32, 255));
            if (ch == CHAR_QUOTE || ch == CHAR_BACKSLASH || ch == CHAR_DEL) begin
               ch = 8'($urandom_range(ANY_BYTE_LO, ANY_BYTE_HI));
            end
            push_byte(ch, 1'b0);
         end else if (roll < 65) begin
            do begin
               ch = 8'($urandom_range(0, 255));
            end while (unescape_simple(ch) < 0);
            push_escape(ch);
         end else if (roll < 85) begin
            case ($urandom_range(0, 3))
               0: cp = 16'($urandom_range(0, 16'h007F));
               1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
               2: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
               default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            push_unicode(cp, $urandom_range(0, 99) < 12);
         end else if (roll < 90) begin
            // Control byte or DEL in the body.
            ch = $urandom_range(0, 5) == 0 ? CHAR_DEL : 8'($urandom_range(0, CTRL_LAST));
            push_byte(ch, 1'b0);
            aborted = 1'b1;
         end else if (roll < 94) begin
            // Unknown escape.
            do begin
               ch = 8'($urandom_range(0, 255));
            end while (unescape_simple(ch) >= 0 || ch == CHAR_LOWER_U);
            push_escape(ch);
            aborted = 1'b1;
         end else if (roll < 97) begin
            // NUL partway through a hex group.
            push_escape(CHAR_LOWER_U);
            digits = $urandom_range(0, 3);
            for (int i = 0; i < digits; i++) begin
               push_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
            end
            push_byte(CHAR_NUL, 1'b0);
            aborted = 1'b1;
         end else begin
            // A new string starts over an unfinished one.
            push_byte(8'($urandom_range(0, 255)), 1'b1);
         end
      end
      if (!aborted && $urandom_range(0, 9) != 0) begin
         push_byte(CHAR_QUOTE, 1'b0);
      end
      // Stray bytes after the string; once it has ended the block ignores them.
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            pending_bytes.push_back('{ch: 8'($urandom_range(0, 255)), start: 1'b0});
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("Mismatch on result %0d: %s is %0h, expected %0h",
                  results_checked, what, got, want);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Request driver: takes the next byte from the pending queue and holds it
   // until the transaction is accepted.
   always @(posedge clock) begin : drive_bytes
      src_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_in_byte, req_begin_req);
            bytes_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 &&
                (quiet_stretch || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               nxt = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= nxt.ch;
               req_begin_req <= nxt.start;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted transaction against the oldest
   // owed result and drives the stall, including one long hold-off.
   always @(posedge clock) begin : check_results
      result_type want;
      int         hold_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (owed_results.size() == 0) begin
               report_mismatch("result with nothing owed, status", rsp_status, 0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_byte_a !== want.byte_a) begin
                  report_mismatch("byte_a", rsp_byte_a, want.byte_a);
               end
               if (rsp_byte_b !== want.byte_b) begin
                  report_mismatch("byte_b", rsp_byte_b, want.byte_b);
               end
               if (rsp_byte_c !== want.byte_c) begin
                  report_mismatch("byte_c", rsp_byte_c, want.byte_c);
               end
               if (rsp_byte_count !== want.byte_count) begin
                  report_mismatch("byte_count", rsp_byte_count, want.byte_count);
               end
               if (rsp_status !== want.status) begin
                  report_mismatch("status", rsp_status, want.status);
               end
               case (want.status)
                  STATUS_END: end_results++;
                  STATUS_ERROR: error_results++;
                  default: data_results++;
               endcase
               if (want.byte_count == 2'd3) begin
                  three_byte_results++;
               end
            end
         end
         if (cycle_count == STALL_START) begin
            hold_left = STALL_CYCLES;
         end
         rsp_stall <= (hold_left > 0) ||
                      (!quiet_stretch && $urandom_range(0, 99) < IDLE_PERCENT);
         if (hold_left > 0) begin
            hold_left--;
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus and end of run.
   initial begin
      // Directed part: a stray byte while idle, an opening quote of value 0,
      // extreme plain bytes, escapes, a surrogate code, a control byte,
      // a new string over a busy one, a NUL escape and a NUL in a hex group.
      pending_bytes.push_back('{ch: 8'hFF, start: 1'b0});
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(CHAR_SPACE, 1'b0);
      push_escape(CHAR_LOWER_N);
      push_escape(CHAR_QUOTE);
      push_unicode(16'hD83F, 1'b0);
      push_byte(CTRL_LAST, 1'b0);
      push_byte(CHAR_QUOTE, 1'b1);
      push_byte(CHAR_QUOTE, 1'b0);
      push_byte(8'h41, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_escape(CHAR_NUL);
      push_byte(CHAR_QUOTE, 1'b1);
      push_escape(CHAR_LOWER_U);
      push_byte(CHAR_NUL, 1'b0);

      while (counted_bytes < TARGET_BYTES) begin
         push_random_string();
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (owed_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d bytes in %0d strings, one long receiver hold-off.",
               bytes_taken, strings_begun);
      $display("Checked %0d data (%0d of three bytes), %0d end and %0d error results.",
               data_results, three_byte_results, end_results, error_results);
      if (mismatch_count == 0 && owed_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/jsu_pkg.sv
hw/rtl/json_string_unescape_utf8_top.sv
bench/tb_top.sv
